>>> design/alpe_pkg.sv
// Shared types and constants of the addressable LED pixel encoder.
package alpe_pkg;

	// Bit-level constants
	localparam int unsigned BITS_PER_PIXEL = 24;
	localparam int unsigned CNT_W          = 5;
	localparam int unsigned TICK_W         = 16;
	localparam int unsigned PROD_W         = 24;

	// Full-scale divisor (255 * 255) and its 2^32 reciprocal, rounded down
	localparam logic [15:0] FULL_SCALE  = 16'd65025;
	localparam logic [16:0] RECIP       = 17'd66051;
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned RECIP_PW    = PROD_W + 17;

	// Register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_BRIGHTNESS = 3'd0,
		REG_COLOR_ORDER = 3'd1,
		REG_ZERO_HIGH = 3'd2,
		REG_ZERO_LOW = 3'd3,
		REG_ONE_HIGH = 3'd4,
		REG_ONE_LOW = 3'd5,
		REG_LATCH = 3'd6
	} alpe_reg_e;

	// Byte order on the wire
	typedef enum logic [1:0] {
		ORDER_RGB = 2'd0,
		ORDER_GRB = 2'd1,
		ORDER_BRG = 2'd2,
		ORDER_BGR = 2'd3
	} alpe_order_e;

	// Reset values of the registers
	localparam logic [7:0]        RST_BRIGHTNESS = 8'd255;
	localparam alpe_order_e       RST_ORDER      = ORDER_GRB;
	localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 16'd4;
	localparam logic [TICK_W-1:0] RST_ZERO_LOW   = 16'd8;
	localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 16'd8;
	localparam logic [TICK_W-1:0] RST_ONE_LOW    = 16'd4;
	localparam logic [TICK_W-1:0] RST_LATCH      = 16'd500;

	// Symbol timing handed to the serializer
	typedef struct packed {
		logic [TICK_W-1:0] zero_high;
		logic [TICK_W-1:0] zero_low;
		logic [TICK_W-1:0] one_high;
		logic [TICK_W-1:0] one_low;
		logic [TICK_W-1:0] latch;
	} alpe_timing_t;

	// Scaled channel products, before the divide
	typedef struct packed {
		logic [PROD_W-1:0] r;
		logic [PROD_W-1:0] g;
		logic [PROD_W-1:0] b;
		logic              last;
	} alpe_prod_t;

	// Finished pixel word in wire order
	typedef struct packed {
		logic [BITS_PER_PIXEL-1:0] word;
		logic                      last;
	} alpe_pix_t;

endpackage

>>> design/alpe_scale.sv
// Two-stage scaling: alpha times brightness, then each channel times that scale.
module alpe_scale
	import alpe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       v_in,
	output logic       rdy_in,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] alpha,
	input  logic       last_pixel,
	input  logic [7:0] brightness,
	output logic       v_out,
	input  logic       rdy_out,
	output alpe_prod_t prod
);

	logic        v_s1, v_s2;
	logic        en1, en2;
	logic [15:0] scale_s1;
	logic [7:0]  r_s1, g_s1, b_s1;
	logic        last_s1;
	alpe_prod_t  prod_s2;

	// Advance a stage when it is empty or the next one takes its beat
	assign en2    = !v_s2 || rdy_out;
	assign en1    = !v_s1 || en2;
	assign rdy_in = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= v_in;
			if (en2) v_s2 <= v_s1;
		end
	end

	// Stage 1: combined scale factor
	always_ff @(posedge clk) begin
		if (en1 && v_in) begin
			scale_s1 <= 16'(alpha) * 16'(brightness);
			r_s1     <= red;
			g_s1     <= green;
			b_s1     <= blue;
			last_s1  <= last_pixel;
		end
	end

	// Stage 2: per-channel products
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			prod_s2.r    <= PROD_W'(r_s1) * PROD_W'(scale_s1);
			prod_s2.g    <= PROD_W'(g_s1) * PROD_W'(scale_s1);
			prod_s2.b    <= PROD_W'(b_s1) * PROD_W'(scale_s1);
			prod_s2.last <= last_s1;
		end
	end

	assign v_out = v_s2;
	assign prod  = prod_s2;

endmodule

>>> design/alpe_div.sv
// Two-stage divide by full scale (reciprocal estimate, then correction) and byte ordering.
module alpe_div
	import alpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        v_in,
	output logic        rdy_in,
	input  alpe_prod_t  prod,
	input  alpe_order_e color_order,
	output logic        v_out,
	input  logic        rdy_out,
	output alpe_pix_t   pix
);

	logic                v_s3, v_s4;
	logic                en3, en4;
	logic [PROD_W-1:0]   pr_s3, pg_s3, pb_s3;
	logic [7:0]          qr_s3, qg_s3, qb_s3;
	logic                last_s3;
	logic [RECIP_PW-1:0] er, eg, eb;
	logic [7:0]          br, bg, bb;
	alpe_pix_t           pix_s4;

	// Fix up an estimate that may sit one below the true quotient
	function automatic logic [7:0] div_fix(input logic [PROD_W-1:0] p, input logic [7:0] qe);
		logic [PROD_W-1:0] qm;
		logic [PROD_W-1:0] rem;
		// qe * 65025 = qe * 2^16 - qe * 2^9 + qe
		qm  = (PROD_W'(qe) << 16) - (PROD_W'(qe) << 9) + PROD_W'(qe);
		rem = p - qm;
		return (rem >= PROD_W'(FULL_SCALE)) ? qe + 8'd1 : qe;
	endfunction

	assign en4    = !v_s4 || rdy_out;
	assign en3    = !v_s3 || en4;
	assign rdy_in = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en3) v_s3 <= v_in;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 3: reciprocal multiply for the quotient estimate
	assign er = RECIP_PW'(prod.r) * RECIP_PW'(RECIP);
	assign eg = RECIP_PW'(prod.g) * RECIP_PW'(RECIP);
	assign eb = RECIP_PW'(prod.b) * RECIP_PW'(RECIP);

	always_ff @(posedge clk) begin
		if (en3 && v_in) begin
			pr_s3   <= prod.r;
			pg_s3   <= prod.g;
			pb_s3   <= prod.b;
			qr_s3   <= er[RECIP_SHIFT +: 8];
			qg_s3   <= eg[RECIP_SHIFT +: 8];
			qb_s3   <= eb[RECIP_SHIFT +: 8];
			last_s3 <= prod.last;
		end
	end

	// Stage 4: correct the quotients and put bytes in wire order
	assign br = div_fix(pr_s3, qr_s3);
	assign bg = div_fix(pg_s3, qg_s3);
	assign bb = div_fix(pb_s3, qb_s3);

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			pix_s4.last <= last_s3;
			case (color_order)
				ORDER_RGB: pix_s4.word <= {br, bg, bb};
				ORDER_GRB: pix_s4.word <= {bg, br, bb};
				ORDER_BRG: pix_s4.word <= {bb, br, bg};
				default:   pix_s4.word <= {bb, bg, br};
			endcase
		end
	end

	assign v_out = v_s4;
	assign pix   = pix_s4;

endmodule

>>> design/alpe_serial.sv
// Symbol serializer: one pulse symbol per beat, MSB first, with a closing reset symbol after a last pixel.
module alpe_serial
	import alpe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                v_in,
	output logic                rdy_in,
	input  alpe_pix_t           pix,
	input  alpe_timing_t        timing,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                drive_high,
	output logic [TICK_W-1:0]   high_ticks,
	output logic [TICK_W-1:0]   low_ticks,
	output logic                last_symbol
);

	logic                      busy_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [BITS_PER_PIXEL-1:0] word_q;
	logic                      last_q;
	logic                      latch_sym;
	logic                      bit_one;
	logic                      take;
	logic                      done;

	assign latch_sym = (cnt_q == CNT_W'(BITS_PER_PIXEL));
	assign bit_one   = word_q[BITS_PER_PIXEL-1];

	// Current symbol from the held word and the timing registers
	assign out_valid   = busy_q;
	assign drive_high  = !latch_sym;
	assign high_ticks  = latch_sym ? timing.latch : (bit_one ? timing.one_high : timing.zero_high);
	assign low_ticks   = latch_sym ? timing.latch : (bit_one ? timing.one_low : timing.zero_low);
	assign last_symbol = latch_sym || (cnt_q == CNT_W'(BITS_PER_PIXEL - 1) && !last_q);

	assign take   = busy_q && out_ready;
	assign done   = take && last_symbol;
	assign rdy_in = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (rdy_in) begin
			// Load the next pixel, possibly right behind the final symbol
			busy_q <= v_in;
			cnt_q  <= '0;
		end else if (take) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Shift the word toward the MSB on each beat
	always_ff @(posedge clk) begin
		if (rdy_in && v_in) begin
			word_q <= pix.word;
			last_q <= pix.last;
		end else if (take) begin
			word_q <= word_q << 1;
		end
	end

endmodule

>>> design/addressable_led_pixel_encoder.sv
// Top level of the addressable LED pixel encoder: registers, pipeline and serializer.
// Each accepted pixel becomes 24 pulse symbols on the output, most significant bit of the
// first wire byte first, plus a closing reset symbol (low in both halves, latch_ticks each)
// when last_pixel is set. The serializer emits one symbol per cycle while out_ready is
// high, and that symbol loop sets the sustained rate. A four-stage front end (scale
// product, channel products, reciprocal estimate, correction and byte ordering) runs
// ahead of it, so the next pixel follows the previous one's final symbol with no gap.
// Registers are written through the cfg port and should change only while no pixel is
// in flight.
module addressable_led_pixel_encoder
	import alpe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [TICK_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic [7:0]        alpha,
	input  logic              last_pixel,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              drive_high,
	output logic [TICK_W-1:0] high_ticks,
	output logic [TICK_W-1:0] low_ticks,
	output logic              last_symbol
);

	logic [7:0]   brightness_q;
	alpe_order_e  order_q;
	alpe_timing_t timing_q;
	logic         v_prod, rdy_prod;
	alpe_prod_t   prod;
	logic         v_pix, rdy_pix;
	alpe_pix_t    pix;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q       <= RST_BRIGHTNESS;
			order_q            <= RST_ORDER;
			timing_q.zero_high <= RST_ZERO_HIGH;
			timing_q.zero_low  <= RST_ZERO_LOW;
			timing_q.one_high  <= RST_ONE_HIGH;
			timing_q.one_low   <= RST_ONE_LOW;
			timing_q.latch     <= RST_LATCH;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BRIGHTNESS:  brightness_q       <= cfg_data[7:0];
				REG_COLOR_ORDER: order_q            <= alpe_order_e'(cfg_data[1:0]);
				REG_ZERO_HIGH:   timing_q.zero_high <= cfg_data;
				REG_ZERO_LOW:    timing_q.zero_low  <= cfg_data;
				REG_ONE_HIGH:    timing_q.one_high  <= cfg_data;
				REG_ONE_LOW:     timing_q.one_low   <= cfg_data;
				REG_LATCH:       timing_q.latch     <= cfg_data;
				default: ;
			endcase
		end
	end

	alpe_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.v_in       (in_valid),
		.rdy_in     (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_pixel (last_pixel),
		.brightness (brightness_q),
		.v_out      (v_prod),
		.rdy_out    (rdy_prod),
		.prod       (prod)
	);

	alpe_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_in        (v_prod),
		.rdy_in      (rdy_prod),
		.prod        (prod),
		.color_order (order_q),
		.v_out       (v_pix),
		.rdy_out     (rdy_pix),
		.pix         (pix)
	);

	alpe_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_in        (v_pix),
		.rdy_in      (rdy_pix),
		.pix         (pix),
		.timing      (timing_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive_high  (drive_high),
		.high_ticks  (high_ticks),
		.low_ticks   (low_ticks),
		.last_symbol (last_symbol)
	);

endmodule

>>> design/alpe_checker.sv
// Port-level checks of the pixel encoder, bound to the top level.
module alpe_checker
	import alpe_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              drive_high,
	input logic [TICK_W-1:0] high_ticks,
	input logic [TICK_W-1:0] low_ticks,
	input logic              last_symbol
);

	// A stalled beat holds its drive level and last flag
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_high) && $stable(last_symbol))
		else $error("stalled symbol changed");

	// The reset symbol always closes its pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_high |-> last_symbol)
		else $error("reset symbol not marked last");

	// Both halves of the reset symbol share one duration
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_high |-> high_ticks == low_ticks)
		else $error("reset symbol halves differ");

	// Symbols of one pixel follow without a gap
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_symbol |=> out_valid)
		else $error("gap inside a pixel");

endmodule

bind addressable_led_pixel_encoder alpe_checker u_alpe_checker (.*);

>>> verif/tb_addressable_led_pixel_encoder.sv
// Self-checking testbench of the addressable LED pixel encoder: pixel beats in, pulse symbols out.
module tb_addressable_led_pixel_encoder
	import alpe_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED  = 3'd7;
	localparam int         HOLD_CYCLES = 400;
	localparam int         CYCLE_LIMIT = 500000;
	localparam int         RAND_PHASES = 8;
	localparam int         PHASE_ITEMS = 57;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} pixel_t;

	typedef struct packed {
		logic              drive_high;
		logic [TICK_W-1:0] high_ticks;
		logic [TICK_W-1:0] low_ticks;
		logic              last_symbol;
	} symbol_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_write   = 1'b0;
	logic [2:0]        cfg_index   = '0;
	logic [TICK_W-1:0] cfg_data    = '0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [7:0]        red         = '0;
	logic [7:0]        green       = '0;
	logic [7:0]        blue        = '0;
	logic [7:0]        alpha       = '0;
	logic              last_pixel  = 1'b0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic              drive_high;
	logic [TICK_W-1:0] high_ticks;
	logic [TICK_W-1:0] low_ticks;
	logic              last_symbol;

	// Shadow copy of the register file
	logic [7:0]        brightness_r = RST_BRIGHTNESS;
	alpe_order_e       order_r      = RST_ORDER;
	logic [TICK_W-1:0] zero_high_r  = RST_ZERO_HIGH;
	logic [TICK_W-1:0] zero_low_r   = RST_ZERO_LOW;
	logic [TICK_W-1:0] one_high_r   = RST_ONE_HIGH;
	logic [TICK_W-1:0] one_low_r    = RST_ONE_LOW;
	logic [TICK_W-1:0] latch_r      = RST_LATCH;

	pixel_t  pixel_q[$];
	symbol_t pending_symbols[$];
	symbol_t got_sym;
	symbol_t want_sym;

	int  err_cnt   = 0;
	int  cycles    = 0;
	int  src_gap   = 0;
	int  sink_gap  = 0;
	int  hold_cnt  = 0;
	int  hold_req  = 0;
	int  hold_seen = 0;
	bit  idle_en   = 1'b1;

	addressable_led_pixel_encoder i_dut (.*);

	always #5 clk = ~clk;

	// Scale one channel by alpha times brightness, floor-divided by full scale
	function automatic logic [7:0] scale_byte(logic [7:0] ch, logic [15:0] scale);
		logic [23:0] prod;
		prod = 24'(ch) * 24'(scale);
		return 8'(prod / 24'd65025);
	endfunction

	// Turn one pixel into its wire symbols under the current register values
	function automatic void encode_pixel(pixel_t p);
		logic [15:0] scale;
		logic [7:0]  rb;
		logic [7:0]  gb;
		logic [7:0]  bb;
		logic [23:0] word;
		symbol_t     s;
		scale = 16'(p.alpha) * 16'(brightness_r);
		rb = scale_byte(p.red, scale);
		gb = scale_byte(p.green, scale);
		bb = scale_byte(p.blue, scale);
		case (order_r)
			ORDER_RGB: word = {rb, gb, bb};
			ORDER_GRB: word = {gb, rb, bb};
			ORDER_BRG: word = {bb, rb, gb};
			default:   word = {bb, gb, rb};
		endcase
		for (int i = BITS_PER_PIXEL - 1; i >= 0; i--) begin
			s.drive_high  = 1'b1;
			s.high_ticks  = word[i] ? one_high_r : zero_high_r;
			s.low_ticks   = word[i] ? one_low_r : zero_low_r;
			s.last_symbol = !p.last && (i == 0);
			pending_symbols.push_back(s);
		end
		// Close the frame with the latch symbol
		if (p.last) begin
			s = '{drive_high: 1'b0, high_ticks: latch_r, low_ticks: latch_r, last_symbol: 1'b1};
			pending_symbols.push_back(s);
		end
	endfunction

	task automatic note_error(string msg);
		if (err_cnt < 10)
			$display("ERROR @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// Write one register and mirror it; only called while the block is idle
	task automatic write_reg(logic [2:0] idx, logic [TICK_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_BRIGHTNESS:  brightness_r = data[7:0];
			REG_COLOR_ORDER: order_r      = alpe_order_e'(data[1:0]);
			REG_ZERO_HIGH:   zero_high_r  = data;
			REG_ZERO_LOW:    zero_low_r   = data;
			REG_ONE_HIGH:    one_high_r   = data;
			REG_ONE_LOW:     one_low_r    = data;
			REG_LATCH:       latch_r      = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
			logic last);
		pixel_q.push_back('{red: r, green: g, blue: b, alpha: a, last: last});
	endtask

	// Wait until every pixel is taken and every symbol seen, then let the pipe settle
	task automatic drain();
		while (pixel_q.size() != 0 || pending_symbols.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [TICK_W-1:0] pick_ticks();
		case ($urandom_range(0, 5))
			0:       return 16'd1;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(1, 65535));
			default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	task automatic random_config();
		logic [7:0] br;
		case ($urandom_range(0, 7))
			0:       br = 8'd0;
			1, 2:    br = 8'd255;
			default: br = 8'($urandom_range(1, 255));
		endcase
		write_reg(REG_BRIGHTNESS, {8'($urandom_range(0, 255)), br});
		write_reg(REG_COLOR_ORDER, {14'($urandom_range(0, 16383)), 2'($urandom_range(0, 3))});
		write_reg(REG_ZERO_HIGH, pick_ticks());
		write_reg(REG_ZERO_LOW, pick_ticks());
		write_reg(REG_ONE_HIGH, pick_ticks());
		write_reg(REG_ONE_LOW, pick_ticks());
		write_reg(REG_LATCH, pick_ticks());
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
	endtask

	task automatic random_pixel();
		logic [7:0] a;
		case ($urandom_range(0, 7))
			0:       a = 8'd0;
			1, 2, 3: a = 8'd255;
			default: a = 8'($urandom_range(0, 255));
		endcase
		add_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), a, $urandom_range(0, 3) == 0);
	endtask

	// Pixel driver: predict on each accepted beat, hold while stalled, idle in bursts when idling is enabled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			red        <= '0;
			green      <= '0;
			blue       <= '0;
			alpha      <= '0;
			last_pixel <= 1'b0;
			src_gap = 0;
		end else begin
			if (in_valid && in_ready)
				encode_pixel(pixel_q.pop_front());
			if (in_valid && !in_ready) begin
				// hold the offered beat
			end else if (src_gap != 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				src_gap = $urandom_range(0, 4);
				in_valid <= 1'b0;
			end else if (pixel_q.size() != 0) begin
				in_valid   <= 1'b1;
				red        <= pixel_q[0].red;
				green      <= pixel_q[0].green;
				blue       <= pixel_q[0].blue;
				alpha      <= pixel_q[0].alpha;
				last_pixel <= pixel_q[0].last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Symbol receiver: long hold-off on request, otherwise random stall bursts when idling is enabled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_gap = 0;
			hold_cnt = 0;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_cnt = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (sink_gap != 0) begin
			sink_gap--;
			out_ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			sink_gap = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Symbol monitor: compare each beat with the oldest predicted symbol
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_sym = '{drive_high: drive_high, high_ticks: high_ticks, low_ticks: low_ticks,
				last_symbol: last_symbol};
			if (pending_symbols.size() == 0) begin
				note_error($sformatf("unexpected symbol %p", got_sym));
			end else begin
				want_sym = pending_symbols.pop_front();
				if (got_sym.drive_high !== want_sym.drive_high
						|| got_sym.high_ticks !== want_sym.high_ticks
						|| got_sym.low_ticks !== want_sym.low_ticks
						|| got_sym.last_symbol !== want_sym.last_symbol)
					note_error($sformatf("symbol mismatch: expected %p, got %p",
						want_sym, got_sym));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_addressable_led_pixel_encoder failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values, GRB order: field extremes and bit patterns
		add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		add_pixel(8'h80, 8'h01, 8'hAA, 8'hFF, 1'b0);
		add_pixel(8'h55, 8'hFE, 8'h7F, 8'hFF, 1'b1);
		add_pixel(8'd200, 8'd100, 8'd50, 8'h00, 1'b1);
		add_pixel(8'hFF, 8'h00, 8'h00, 8'h80, 1'b0);
		add_pixel(8'h00, 8'hFF, 8'h00, 8'h01, 1'b1);
		drain();

		// Remaining byte orders, upper data bits set
		write_reg(REG_COLOR_ORDER, {14'h3FFF, ORDER_RGB});
		add_pixel(8'hF0, 8'h0F, 8'h3C, 8'hFF, 1'b0);
		drain();
		write_reg(REG_COLOR_ORDER, {14'h2AAA, ORDER_BRG});
		add_pixel(8'hF0, 8'h0F, 8'h3C, 8'hFF, 1'b1);
		drain();
		write_reg(REG_COLOR_ORDER, {14'h1555, ORDER_BGR});
		add_pixel(8'hF0, 8'h0F, 8'h3C, 8'hFF, 1'b0);
		drain();

		// Zero durations pass through unchanged
		write_reg(REG_ZERO_HIGH, 16'd0);
		write_reg(REG_ZERO_LOW, 16'd0);
		write_reg(REG_ONE_HIGH, 16'd0);
		write_reg(REG_ONE_LOW, 16'd0);
		write_reg(REG_LATCH, 16'd0);
		add_pixel(8'hA5, 8'h5A, 8'hC3, 8'hFF, 1'b1);
		add_pixel(8'h3C, 8'hC3, 8'h81, 8'hFF, 1'b0);
		drain();

		// Longest durations
		write_reg(REG_ZERO_HIGH, 16'hFFFF);
		write_reg(REG_ZERO_LOW, 16'hFFFF);
		write_reg(REG_ONE_HIGH, 16'hFFFF);
		write_reg(REG_ONE_LOW, 16'hFFFF);
		write_reg(REG_LATCH, 16'hFFFF);
		add_pixel(8'hA5, 8'h5A, 8'hC3, 8'hFF, 1'b1);
		add_pixel(8'hFF, 8'h00, 8'hFF, 8'hFE, 1'b0);
		drain();

		// Brightness extremes, upper data bits dropped
		write_reg(REG_ONE_HIGH, 16'd7);
		write_reg(REG_ZERO_LOW, 16'd3);
		write_reg(REG_BRIGHTNESS, 16'hAB00);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		drain();
		write_reg(REG_BRIGHTNESS, 16'hFF01);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		drain();

		// Out-of-range index leaves every register alone
		write_reg(REG_BRIGHTNESS, 16'd255);
		write_reg(REG_UNUSED, 16'hFFFF);
		add_pixel(8'h96, 8'h69, 8'hF0, 8'hFF, 1'b1);
		drain();

		// Random phases; long receiver hold-off in one, no idling in the last ones
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			idle_en = (ph < RAND_PHASES - 2);
			random_config();
			@(negedge clk);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_pixel();
			if (ph == 3)
				hold_req++;
			drain();
		end

		repeat (30) @(negedge clk);
		if (pending_symbols.size() != 0)
			note_error($sformatf("%0d symbols never arrived", pending_symbols.size()));
		if (err_cnt == 0)
			$display("tb_addressable_led_pixel_encoder passed");
		else
			$display("tb_addressable_led_pixel_encoder failed");
		$finish;
	end

endmodule

>>> sim.f
design/alpe_pkg.sv
design/alpe_scale.sv
design/alpe_div.sv
design/alpe_serial.sv
design/addressable_led_pixel_encoder.sv
design/alpe_checker.sv
verif/tb_addressable_led_pixel_encoder.sv
